// ===== sv/kwc_pkg.sv =====
`default_nettype none

package kwc_pkg;

    localparam int KW_BYTES    = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int KW_LEN_W    = 5;
    localparam int COUNT_W     = 32;

    typedef logic [7:0]             t_byte;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;
    typedef logic [COUNT_W-1:0]     t_count;

    localparam t_cfg_idx CFG_KEYWORD_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_KEYWORD_LOW    = 2'd1;
    localparam t_cfg_idx CFG_KEYWORD_HIGH   = 2'd2;

    localparam t_byte CHAR_NUL     = 8'h00;
    localparam t_byte CHAR_NEWLINE = 8'h0A;

endpackage

`default_nettype wire

// ===== sv/kwc_in_if.sv =====
`default_nettype none

interface kwc_in_if;
    import kwc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== sv/kwc_out_if.sv =====
`default_nettype none

interface kwc_out_if;
    import kwc_pkg::*;

    logic   valid;
    logic   ready;
    t_count match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

`default_nettype wire

// ===== sv/kwc_window_cmp.sv =====
`default_nettype none

module kwc_window_cmp #(
    parameter int MAX_KEYWORD = 16,
    parameter int LEN_W       = $clog2(MAX_KEYWORD + 1)
) (
    input  kwc_pkg::t_byte    i_window  [MAX_KEYWORD],
    input  kwc_pkg::t_byte    i_keyword [MAX_KEYWORD],
    input  logic [LEN_W-1:0]  i_len,
    output logic              o_match
);
    import kwc_pkg::*;

    localparam int IDX_W = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1;

    logic [MAX_KEYWORD-1:0] lane_ok;

    // Window entry j holds the j-th newest byte; it lines up with keyword byte len-1-j.
    always_comb begin
        for (int j = 0; j < MAX_KEYWORD; j++) begin
            logic [LEN_W-1:0] pos;
            pos = i_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < i_len) begin
                lane_ok[j] = (i_window[j] == i_keyword[pos[IDX_W-1:0]]);
            end else begin
                lane_ok[j] = 1'b1;
            end
        end
    end

    assign o_match = (i_len != '0) && (&lane_ok);

endmodule

`default_nettype wire

// ===== sv/keyword_occurrence_counter_core.sv =====
// Keyword occurrence counter.
// Counts non-overlapping, leftmost occurrences of a keyword of up to
// MAX_KEYWORD bytes in a byte stream; matches never span lines.
// Channels: i_text carries text_byte and end_of_text, o_count carries
// match_count, both valid/ready. One result is produced per text, for the
// byte marked end_of_text, and it is the saturating 32-bit count.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write keyword_length
// (index 0), keyword bytes 0-7 (index 1) and bytes 8-15 (index 2); write
// only while no text is in flight.
// Throughput: one byte per cycle. A byte sits in the input register,
// where the parallel window compare runs, then updates state.
// The count is registered when the last byte leaves the input register.
// A stalled receiver holds the count in the output register; bytes keep
// flowing until a second end_of_text byte needs that register.
// Reset clears the keyword registers, the counter and the line state.
`default_nettype none

module keyword_occurrence_counter_core #(
    parameter int MAX_KEYWORD = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  kwc_pkg::t_cfg_idx     i_cfg_idx,
    input  kwc_pkg::t_cfg_data    i_cfg_data,
    kwc_in_if.sink                i_text,
    kwc_out_if.source             o_count
);
    import kwc_pkg::*;

    localparam int LEN_W  = $clog2(MAX_KEYWORD + 1);
    localparam int SKIP_W = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1;

    // configuration
    logic [KW_LEN_W-1:0]   r_kw_len;
    logic [CFG_DATA_W-1:0] r_kw_low;
    logic [CFG_DATA_W-1:0] r_kw_high;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    // line state
    t_byte             r_window [MAX_KEYWORD];
    t_byte             n_window [MAX_KEYWORD];
    logic [LEN_W-1:0]  r_fill,    n_fill;
    logic [SKIP_W-1:0] r_skip,    n_skip;
    logic              r_stopped, n_stopped;
    t_count            r_count,   n_count;

    // output register
    logic   r_out_valid;
    t_count r_out_count;

    logic [2*CFG_DATA_W-1:0] kw_flat;
    t_byte                   keyword [MAX_KEYWORD];
    logic [LEN_W-1:0]        len_eff;
    logic                    step;
    logic                    win_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_len  <= '0;
            r_kw_low  <= '0;
            r_kw_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEYWORD_LENGTH: r_kw_len  <= i_cfg_data[KW_LEN_W-1:0];
                CFG_KEYWORD_LOW:    r_kw_low  <= i_cfg_data;
                CFG_KEYWORD_HIGH:   r_kw_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign kw_flat = {r_kw_high, r_kw_low};

    always_comb begin
        for (int k = 0; k < MAX_KEYWORD; k++) begin
            keyword[k] = kw_flat[8*k +: 8];
        end
    end

    assign len_eff = (r_kw_len > KW_LEN_W'(MAX_KEYWORD)) ? LEN_W'(MAX_KEYWORD)
                                                          : r_kw_len[LEN_W-1:0];

    // A last byte needs the output register; others always advance.
    assign step = r_in_valid && (!r_in_last || !r_out_valid || o_count.ready);
    assign i_text.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.end_of_text;
        end
    end

    always_comb begin
        n_window[0] = r_in_byte;
        for (int i = 1; i < MAX_KEYWORD; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    kwc_window_cmp #(
        .MAX_KEYWORD (MAX_KEYWORD),
        .LEN_W       (LEN_W)
    ) u_cmp (
        .i_window  (n_window),
        .i_keyword (keyword),
        .i_len     (len_eff),
        .o_match   (win_match)
    );

    always_comb begin
        n_fill    = r_fill;
        n_skip    = r_skip;
        n_stopped = r_stopped;
        n_count   = r_count;
        if (!r_stopped) begin
            if (r_in_byte == CHAR_NUL) begin
                n_stopped = 1'b1;
            end else begin
                if (r_fill < LEN_W'(MAX_KEYWORD)) begin
                    n_fill = r_fill + LEN_W'(1);
                end
                if (r_skip != '0) begin
                    n_skip = r_skip - SKIP_W'(1);
                end else if (win_match && (n_fill >= len_eff)) begin
                    if (r_count != '1) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    n_skip = SKIP_W'(len_eff - LEN_W'(1));
                end
            end
        end
        if (r_in_byte == CHAR_NEWLINE) begin
            n_fill    = '0;
            n_skip    = '0;
            n_stopped = 1'b0;
        end
    end

    // Window contents past the fill count never affect a match: no reset needed.
    always_ff @(posedge i_clk) begin
        if (step && !r_stopped && (r_in_byte != CHAR_NUL)) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_skip    <= '0;
            r_stopped <= 1'b0;
            r_count   <= '0;
        end else if (step) begin
            if (r_in_last) begin
                r_fill    <= '0;
                r_skip    <= '0;
                r_stopped <= 1'b0;
                r_count   <= '0;
            end else begin
                r_fill    <= n_fill;
                r_skip    <= n_skip;
                r_stopped <= n_stopped;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_count.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_count <= n_count;
        end
    end

    assign o_count.valid       = r_out_valid;
    assign o_count.match_count = r_out_count;

    // A pending skip only follows a match inside the current line.
    a_skip_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> (r_fill != '0))
        else $error("skip pending on an empty line");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |=> r_out_valid)
        else $error("last byte produced no result");

    a_nul_stops_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !r_in_last && (r_in_byte == CHAR_NUL)) |=> r_stopped)
        else $error("terminator byte did not stop the line");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
    import kwc_pkg::*;

    localparam int GAP_MAX        = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PRESSURE_HOLD  = 200;
    localparam int RANDOM_BYTES   = 1000;
    localparam int PHASE_BYTES    = 100;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_cfg_we   = 1'b0;
    t_cfg_idx  i_cfg_idx  = CFG_KEYWORD_LENGTH;
    t_cfg_data i_cfg_data = '0;

    kwc_in_if  text_if ();
    kwc_out_if count_if ();

    keyword_occurrence_counter_core #(
        .MAX_KEYWORD(KW_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_text     (text_if),
        .o_count    (count_if)
    );

    // keyword registers as the block should hold them
    logic [KW_LEN_W-1:0] kw_len  = '0;
    t_cfg_data           kw_low  = '0;
    t_cfg_data           kw_high = '0;

    // line state of the counter
    t_byte  line_window [KW_BYTES] = '{default: '0};
    int     line_fill       = 0;
    int     skip_left       = 0;
    bit     line_stopped    = 1'b0;
    t_count running_matches = '0;

    t_count expected_counts [$];

    int     errors             = 0;
    int     bytes_sent         = 0;
    int     counts_checked     = 0;
    int     settings_used      = 0;
    int     input_stall_cycles = 0;
    int     quiet_cycles       = 0;
    t_count top_count          = '0;

    int     tx_gap_max = 0;
    int     rx_gap_max = 0;
    int     rx_hold    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_byte kw_byte(int k);
        logic [2*CFG_DATA_W-1:0] kw;
        kw = {kw_high, kw_low};
        return kw[8*k +: 8];
    endfunction

    function automatic void predict_byte(t_byte b, bit last);
        int len;
        int i;
        bit hit;
        len = (kw_len > KW_BYTES) ? KW_BYTES : int'(kw_len);
        if (!line_stopped) begin
            if (b == CHAR_NUL) begin
                line_stopped = 1'b1;
            end else begin
                for (i = KW_BYTES - 1; i > 0; i--) line_window[i] = line_window[i-1];
                line_window[0] = b;
                if (line_fill < KW_BYTES) line_fill++;
                hit = (len > 0) && (line_fill >= len);
                for (i = 0; i < len; i++) begin
                    if (line_window[i] != kw_byte(len - 1 - i)) hit = 1'b0;
                end
                if (skip_left > 0) begin
                    skip_left--;
                end else if (hit) begin
                    if (running_matches != '1) running_matches++;
                    skip_left = len - 1;
                end
            end
        end
        // newline is matched first, then it resets the line
        if (b == CHAR_NEWLINE) begin
            line_fill    = 0;
            skip_left    = 0;
            line_stopped = 1'b0;
        end
        if (last) begin
            expected_counts.push_back(running_matches);
            line_window     = '{default: '0};
            line_fill       = 0;
            skip_left       = 0;
            line_stopped    = 1'b0;
            running_matches = '0;
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_counts
        t_count want;
        if (i_rst_n) begin
            if (text_if.valid && text_if.ready) begin
                predict_byte(text_if.text_byte, text_if.end_of_text);
                bytes_sent++;
            end
            if (text_if.valid && !text_if.ready) input_stall_cycles++;
            if (count_if.valid && count_if.ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("match_count %0d with no text ended",
                                              count_if.match_count));
                end else begin
                    want = expected_counts.pop_front();
                    if (count_if.match_count !== want)
                        report_mismatch($sformatf("match_count %0d, want %0d",
                                                  count_if.match_count, want));
                    counts_checked++;
                    if (want > top_count) top_count = want;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((text_if.valid && text_if.ready) || (count_if.valid && count_if.ready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : count_sink
        int stall;
        count_if.ready <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = (rx_hold > 0) ? rx_hold : $urandom_range(rx_gap_max, 0);
            rx_hold = 0;
            if (stall > 0) begin
                count_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            count_if.ready <= 1'b1;
            do @(posedge i_clk); while (!count_if.valid);
            @(negedge i_clk);
        end
    end

    // enter and leave at a falling edge; valid stays up when no gap is drawn
    task automatic send_byte(t_byte b, bit last);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= last;
        do @(posedge i_clk); while (!text_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(t_byte seq[$]);
        foreach (seq[k]) send_byte(seq[k], k == seq.size() - 1);
    endtask

    task automatic wait_idle();
        text_if.valid <= 1'b0;
        while (expected_counts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_keyword(int len, t_cfg_data low, t_cfg_data high);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEYWORD_LENGTH;
        i_cfg_data <= t_cfg_data'(len[KW_LEN_W-1:0]);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_KEYWORD_LOW;
        i_cfg_data <= low;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_KEYWORD_HIGH;
        i_cfg_data <= high;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        kw_len  = len[KW_LEN_W-1:0];
        kw_low  = low;
        kw_high = high;
        settings_used++;
    endtask

    // mostly keyword copies and keyword letters, with line breaks,
    // terminators and arbitrary bytes mixed in
    task automatic send_random_text(int n);
        t_byte seq[$];
        int    len;
        int    k;
        int    r;
        len = (kw_len > KW_BYTES) ? KW_BYTES : int'(kw_len);
        while (seq.size() < n) begin
            r = $urandom_range(99, 0);
            if (len > 0 && r < 25) begin
                for (k = 0; k < len; k++) seq.push_back(kw_byte(k));
            end else if (r < 35) begin
                seq.push_back(CHAR_NEWLINE);
            end else if (r < 39) begin
                seq.push_back(CHAR_NUL);
            end else if (r < 50) begin
                seq.push_back(t_byte'($urandom_range(255, 0)));
            end else if (len > 0) begin
                seq.push_back(kw_byte($urandom_range(len - 1, 0)));
            end else begin
                seq.push_back(t_byte'("a" + $urandom_range(2, 0)));
            end
        end
        send_bytes(seq);
    endtask

    task automatic test_reset_length_zero();
        send_bytes('{"a", "a", 8'hFF});
    endtask

    task automatic test_non_overlap();
        wait_idle();
        load_keyword(2, 64'h6161, '0);
        send_bytes('{"a", "a", "a"});
    endtask

    task automatic test_line_rules();
        wait_idle();
        load_keyword(2, 64'h6261, '0);
        send_bytes('{"a", CHAR_NEWLINE, "b"});
        // terminator stops the line until the newline
        send_bytes('{CHAR_NUL, "a", "b", CHAR_NEWLINE, "a", "b"});
    endtask

    task automatic test_newline_in_keyword();
        wait_idle();
        load_keyword(2, {56'h0, CHAR_NEWLINE} | 64'h6200, '0);
        send_bytes('{"b", CHAR_NEWLINE, "b", CHAR_NEWLINE});
    endtask

    task automatic test_oversize_length();
        t_byte seq[$];
        wait_idle();
        load_keyword(31, '1, '1);
        repeat (KW_BYTES + 1) seq.push_back(8'hFF);
        send_bytes(seq);
    endtask

    task automatic test_random_texts(int total);
        logic [2*CFG_DATA_W-1:0] kw;
        int start;
        int phase_start;
        int len;
        int r;
        int k;
        start = bytes_sent;
        while (bytes_sent - start < total) begin
            wait_idle();
            r = $urandom_range(9, 0);
            case (r)
                0:       len = 0;
                1:       len = 1;
                2:       len = KW_BYTES;
                3:       len = $urandom_range(31, KW_BYTES + 1);
                4:       len = $urandom_range(KW_BYTES, 7);
                default: len = $urandom_range(6, 2);
            endcase
            for (k = 0; k < KW_BYTES; k++) begin
                r = $urandom_range(99, 0);
                if (r < 80)      kw[8*k +: 8] = t_byte'("a" + $urandom_range(2, 0));
                else if (r < 85) kw[8*k +: 8] = CHAR_NEWLINE;
                else if (r < 88) kw[8*k +: 8] = CHAR_NUL;
                else             kw[8*k +: 8] = t_byte'($urandom_range(255, 0));
            end
            load_keyword(len, kw[CFG_DATA_W-1:0], kw[2*CFG_DATA_W-1:CFG_DATA_W]);
            // the first two phases run flat out on both sides
            if (settings_used > 6) begin
                r = $urandom_range(2, 0);
                tx_gap_max = (r == 0) ? 0 : (r == 1) ? 4 : GAP_MAX;
                r = $urandom_range(2, 0);
                rx_gap_max = (r == 0) ? 0 : (r == 1) ? 4 : GAP_MAX;
            end else begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_text($urandom_range(30, 1));
        end
    endtask

    // hold the count output while short texts keep coming, so the input backs up
    task automatic test_backpressure();
        wait_idle();
        load_keyword(2, 64'h6261, '0);
        tx_gap_max = 0;
        rx_hold    = PRESSURE_HOLD;
        repeat (30) send_random_text(3);
        rx_gap_max = GAP_MAX;
        tx_gap_max = GAP_MAX;
    endtask

    initial begin
        text_if.valid       <= 1'b0;
        text_if.text_byte   <= '0;
        text_if.end_of_text <= 1'b0;
        tx_gap_max = 3;
        rx_gap_max = 3;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_length_zero();
        test_non_overlap();
        test_line_rules();
        test_newline_in_keyword();
        test_oversize_length();
        test_random_texts(RANDOM_BYTES);
        test_backpressure();
        wait_idle();

        $display("summary: %0d text bytes, %0d counts checked, %0d keyword settings",
                 bytes_sent, counts_checked, settings_used);
        $display("summary: highest count %0d, %0d cycles with the input held off",
                 top_count, input_stall_cycles);
        if (errors == 0 && expected_counts.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
